/* src/stp_pkg.sv */
package stp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CHAR_W   = 8;
    localparam int DATA_W   = 32;
    localparam int ACTION_W = 2;
    localparam int PART_W   = 5;
    localparam int FILL_W   = 3;
    localparam int CNT_W    = 3;
    localparam int BITS_W   = 36;

    localparam logic [CHAR_W-1:0] OFFSET_RESET = 8'h28;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE  = 2'd0,
        ACT_WORD  = 2'd1,
        ACT_FLUSH = 2'd2
    } t_action;

    // One queued job: up to six sextets, lowest first, and how many of them to send
    typedef struct packed {
        logic [BITS_W-1:0] bits;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

endpackage

/* src/sextet_text_packer.sv */
// Path: an accepted beat passes through the job queue, the working slot and the output register
// before its first character shows. Throughput: one character per clock on the master side
// while jobs wait and the receiver is ready; a word beat gives 5 or 6 characters, a byte beat
// 1 or 2, a flush at most 1; input beats are taken every clock while the job queue has room.
// Reset: synchronous, active low; clears the pending sextet, queue and output, offset to 0x28.
module sextet_text_packer #(
    parameter int QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [stp_pkg::DATA_W-1:0]      i_s_axis_tdata,   // [31:0] data
    input  logic [stp_pkg::ACTION_W-1:0]    i_s_axis_tuser,   // [1:0] action
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [stp_pkg::CHAR_W-1:0]      o_m_axis_tdata,   // [7:0] out_char
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [stp_pkg::CHAR_W-1:0]      i_cfg_wdata
);

    logic            push, q_ready, q_valid, pop;
    stp_pkg::t_entry push_entry, q_entry;

    stp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_action  (i_s_axis_tuser),
        .i_data    (i_s_axis_tdata),
        .i_q_ready (q_ready),
        .o_ready   (o_s_axis_tready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    stp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    stp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_char      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

/* src/stp_front.sv */
module stp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [stp_pkg::ACTION_W-1:0]    i_action,
    input  logic [stp_pkg::DATA_W-1:0]      i_data,
    input  logic                            i_q_ready,
    output logic                            o_ready,
    output logic                            o_push,
    output stp_pkg::t_entry                 o_entry
);

    logic [stp_pkg::PART_W-1:0] r_part, n_part, c_part;
    logic [stp_pkg::FILL_W-1:0] r_fill, n_fill, c_fill;
    logic [40:0]                acc;
    logic [5:0]                 total;
    logic                       produce;
    logic                       accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        acc     = '0;
        total   = '0;
        produce = 1'b0;
        c_part  = r_part;
        c_fill  = r_fill;
        o_entry = '0;
        case (stp_pkg::t_action'(i_action))
            stp_pkg::ACT_BYTE: begin
                acc     = {36'd0, r_part} | ({33'd0, i_data[7:0]} << r_fill);
                total   = {3'd0, r_fill} + 6'd8;
                produce = 1'b1;
                o_entry.bits = acc[stp_pkg::BITS_W-1:0];
                if (total >= 6'd12) begin
                    o_entry.cnt = 3'd2;
                    c_part      = acc[16:12];
                    c_fill      = 3'(total - 6'd12);
                end else begin
                    o_entry.cnt = 3'd1;
                    c_part      = acc[10:6];
                    c_fill      = 3'(total - 6'd6);
                end
            end
            stp_pkg::ACT_WORD: begin
                acc     = {36'd0, r_part} | ({9'd0, i_data} << r_fill);
                total   = {3'd0, r_fill} + 6'd32;
                produce = 1'b1;
                o_entry.bits = acc[stp_pkg::BITS_W-1:0];
                if (total >= 6'd36) begin
                    o_entry.cnt = 3'd6;
                    c_part      = acc[40:36];
                    c_fill      = 3'(total - 6'd36);
                end else begin
                    o_entry.cnt = 3'd5;
                    c_part      = acc[34:30];
                    c_fill      = 3'(total - 6'd30);
                end
            end
            stp_pkg::ACT_FLUSH: begin
                // nothing pending means nothing to send
                if (r_fill != '0) begin
                    produce      = 1'b1;
                    o_entry.bits = {31'd0, r_part};
                    o_entry.cnt  = 3'd1;
                end
                c_part = '0;
                c_fill = '0;
            end
            default: begin
            end
        endcase
        o_push = accept && produce;
        n_part = accept ? c_part : r_part;
        n_fill = accept ? c_fill : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_fill <= '0;
        end else begin
            r_part <= n_part;
            r_fill <= n_fill;
        end
    end

endmodule

/* src/stp_queue.sv */
module stp_queue #(
    parameter int DEPTH = stp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stp_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output stp_pkg::t_entry o_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    stp_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* src/stp_back.sv */
module stp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  stp_pkg::t_entry             i_q_entry,
    output logic                        o_pop,
    input  logic                        i_cfg_we,
    input  logic [stp_pkg::CHAR_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [stp_pkg::CHAR_W-1:0]  o_char,
    output logic                        o_last
);

    logic [stp_pkg::CHAR_W-1:0] r_offset;
    logic [stp_pkg::BITS_W-1:0] r_bits;
    logic [stp_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_ovalid;
    logic [stp_pkg::CHAR_W-1:0] r_char;
    logic                       r_last;
    logic                       advance;

    assign advance = (r_cnt != '0) && (!r_ovalid || i_ready);
    // refill the working slot as its last sextet leaves, so characters run without a gap
    assign o_pop   = i_q_valid && ((r_cnt == '0) || (advance && r_cnt == 3'd1));

    assign o_valid = r_ovalid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= stp_pkg::OFFSET_RESET;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (advance) begin
                r_char   <= {2'b00, r_bits[5:0]} + r_offset;
                r_last   <= (r_cnt == 3'd1);
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_bits <= i_q_entry.bits;
                r_cnt  <= i_q_entry.cnt;
            end else if (advance) begin
                r_bits <= {6'd0, r_bits[stp_pkg::BITS_W-1:6]};
                r_cnt  <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* src/stp_checker.sv */
module stp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [stp_pkg::ACTION_W-1:0]    i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [stp_pkg::CHAR_W-1:0]      o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a word always yields characters, so the output must be busy soon after
    a_word_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == stp_pkg::ACT_WORD)
            |-> ##3 o_m_axis_tvalid)
        else $error("word beat produced no character");

endmodule

bind sextet_text_packer stp_checker u_checker (.*);

/* verif/tb_sextet_text_packer.sv */
`timescale 1ns / 1ps

module tb_sextet_text_packer;

    // action code the block has no use for; it must be swallowed silently
    localparam logic [stp_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BEATS  = 39;

    typedef struct {
        logic [stp_pkg::ACTION_W-1:0] action;
        logic [stp_pkg::DATA_W-1:0]   data;
    } t_in_beat;

    typedef struct {
        logic [stp_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_char_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_axis_tvalid = 1'b0;
    logic                         o_s_axis_tready;
    logic [stp_pkg::DATA_W-1:0]   i_s_axis_tdata = '0;
    logic [stp_pkg::ACTION_W-1:0] i_s_axis_tuser = '0;
    logic                         o_m_axis_tvalid;
    logic                         i_m_axis_tready = 1'b0;
    logic [stp_pkg::CHAR_W-1:0]   o_m_axis_tdata;
    logic                         o_m_axis_tlast;
    logic                         i_cfg_we = 1'b0;
    logic [stp_pkg::CHAR_W-1:0]   i_cfg_wdata = '0;

    // shadow of the packer state
    logic [stp_pkg::CHAR_W-1:0] char_offset = stp_pkg::OFFSET_RESET;
    logic [stp_pkg::PART_W-1:0] partial_sextet = '0;
    int unsigned                filled_bits = 0;

    t_in_beat   pending_beats[$];
    t_char_beat expected_chars[$];

    int unsigned beats_issued = 0;
    int unsigned beats_taken = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    bit          idle_off = 1'b0;

    sextet_text_packer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [31:0] data
        .i_s_axis_tuser  (i_s_axis_tuser),   // [1:0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] out_char
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Work out the characters one accepted beat produces and advance the shadow state.
    task automatic predict_chars(input logic [stp_pkg::ACTION_W-1:0] action,
                                 input logic [stp_pkg::DATA_W-1:0]   data);
        logic [63:0] acc;
        int unsigned total;
        t_char_beat  c;
        case (action)
            stp_pkg::ACT_BYTE, stp_pkg::ACT_WORD: begin
                if (action == stp_pkg::ACT_BYTE) begin
                    acc   = {56'd0, data[7:0]};
                    total = filled_bits + 8;
                end else begin
                    acc   = {32'd0, data};
                    total = filled_bits + stp_pkg::DATA_W;
                end
                acc = (acc << filled_bits) | {59'd0, partial_sextet};
                while (total >= 6) begin
                    c.ch   = {2'b00, acc[5:0]} + char_offset;
                    c.last = (total < 12);
                    expected_chars.push_back(c);
                    acc   = acc >> 6;
                    total = total - 6;
                end
                partial_sextet = acc[stp_pkg::PART_W-1:0];
                filled_bits    = total;
            end
            stp_pkg::ACT_FLUSH: begin
                if (filled_bits != 0) begin
                    c.ch   = {3'b000, partial_sextet} + char_offset;
                    c.last = 1'b1;
                    expected_chars.push_back(c);
                    partial_sextet = '0;
                    filled_bits    = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_beat(input logic [stp_pkg::ACTION_W-1:0] action,
                              input logic [stp_pkg::DATA_W-1:0]   data);
        t_in_beat b;
        b.action = action;
        b.data   = data;
        pending_beats.push_back(b);
    endtask

    // Mostly packing beats with random content, a flush now and then, a little noise.
    task automatic queue_random_beats(input int unsigned count);
        int unsigned                  pick;
        logic [stp_pkg::DATA_W-1:0]   data;
        logic [stp_pkg::ACTION_W-1:0] action;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42)      action = stp_pkg::ACT_BYTE;
            else if (pick < 80) action = stp_pkg::ACT_WORD;
            else if (pick < 92) action = stp_pkg::ACT_FLUSH;
            else                action = ACT_UNUSED;
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = '1;
                default: data = $urandom;
            endcase
            queue_beat(action, data);
        end
    endtask

    task automatic drain;
        while (pending_beats.size() != 0 || beats_taken != beats_issued
               || expected_chars.size() != 0)
            @(posedge i_clk);
        // a trailing flush or unused beat may still be in flight with nothing to show
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [stp_pkg::CHAR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        char_offset = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender: hold a beat until it is taken, then present the next one or idle a while.
    always @(negedge i_clk) begin : drive_input
        t_in_beat nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (beats_taken == beats_issued) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(1, 9) - 1;
                i_s_axis_tvalid <= 1'b0;
            end else begin
                nxt = pending_beats.pop_front();
                i_s_axis_tdata  <= nxt.data;
                i_s_axis_tuser  <= nxt.action;
                i_s_axis_tvalid <= 1'b1;
                beats_issued = beats_issued + 1;
            end
        end
    end

    // Receiver back-pressure in bursts.
    always @(negedge i_clk) begin : drive_ready
        if (idle_off) begin
            stall_left = 0;
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_char_beat want;
        cycle_count = cycle_count + 1;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char: expected none, actual %02h last %0b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                    error_count = error_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_m_axis_tdata !== want.ch) begin
                        $display("%0t: char mismatch: expected %02h, actual %02h",
                                 $time, want.ch, o_m_axis_tdata);
                        error_count = error_count + 1;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $display("%0t: tlast mismatch: expected %0b, actual %0b",
                                 $time, want.last, o_m_axis_tlast);
                        error_count = error_count + 1;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                beats_taken = beats_taken + 1;
                predict_chars(i_s_axis_tuser, i_s_axis_tdata);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset offset, empty flush, unused code, extremes, every fill level
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        queue_beat(ACT_UNUSED, 32'hffff_ffff);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_0000);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_00ff);
        queue_beat(stp_pkg::ACT_BYTE, 32'hffff_ff5a);
        queue_beat(stp_pkg::ACT_FLUSH, 32'hffff_ffff);
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        queue_beat(stp_pkg::ACT_WORD, 32'hffff_ffff);
        queue_beat(stp_pkg::ACT_WORD, 32'h0000_0000);
        queue_beat(stp_pkg::ACT_WORD, 32'haaaa_aaaa);
        queue_beat(ACT_UNUSED, 32'h5555_5555);
        queue_beat(stp_pkg::ACT_WORD, 32'h5555_5555);
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_00a5);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_003c);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_00ff);
        queue_beat(stp_pkg::ACT_WORD, 32'h8000_0001);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_0080);
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        drain();

        write_offset(8'h00);
        queue_beat(stp_pkg::ACT_WORD, 32'hffff_ffff);
        queue_beat(stp_pkg::ACT_BYTE, 32'h0000_00ff);
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        queue_random_beats(RANDOM_BEATS);
        drain();

        // top offset: every sextet above zero wraps past 0xff
        write_offset(8'hff);
        queue_beat(stp_pkg::ACT_WORD, 32'hffff_ffff);
        queue_beat(stp_pkg::ACT_FLUSH, 32'h0000_0000);
        queue_random_beats(RANDOM_BEATS);
        drain();

        write_offset(stp_pkg::CHAR_W'($urandom));
        queue_random_beats(RANDOM_BEATS);
        drain();

        // closing stretch at full rate, back on the reset offset
        write_offset(stp_pkg::OFFSET_RESET);
        idle_off = 1'b1;
        queue_random_beats(RANDOM_BEATS);
        drain();

        if (error_count == 0 && expected_chars.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
